// ===== src/vmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// vmpt_pkg
// Shared types and constants for the vibration motor pulse timer.
// ----------------------------------------------------------------------------
package vmpt_pkg;

  localparam int FIELD_TIME_W = 16;
  localparam int QUEUE_DEPTH  = 2;

  // input command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_PROBE = 2'd2;

  // decoded operation carried from the front end to the execution side
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_PROBE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PRES_PRESENT = 2'd0,
    PRES_ABSENT  = 2'd1,
    PRES_ERROR   = 2'd2
  } pres_t;

  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_STOPPING = 3'd3;
  localparam logic [2:0] MODE_ACTIVE   = 3'd4;

  typedef struct packed {
    op_t                     op;
    logic [FIELD_TIME_W-1:0] total_time;
    logic [FIELD_TIME_W-1:0] on_time;
    logic [FIELD_TIME_W-1:0] off_time;
    logic                    bus_busy;
    logic                    pak_fault;
  } item_t;

endpackage

// ===== src/vmpt_if.sv =====
// ----------------------------------------------------------------------------
// vmpt channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface vmpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] total_time;
  logic [15:0] on_time;
  logic [15:0] off_time;
  logic        bus_busy;
  logic        pak_fault;

  modport source (
    output valid, cmd, total_time, on_time, off_time, bus_busy, pak_fault,
    input  ready
  );
  modport sink (
    input  valid, cmd, total_time, on_time, off_time, bus_busy, pak_fault,
    output ready
  );
endinterface

interface vmpt_out_if;
  logic       valid;
  logic       ready;
  logic       start_sent;
  logic       stop_sent;
  logic       init_sent;
  logic [1:0] pak_status;
  logic [2:0] pattern_mode;

  modport source (
    output valid, start_sent, stop_sent, init_sent, pak_status, pattern_mode,
    input  ready
  );
  modport sink (
    input  valid, start_sent, stop_sent, init_sent, pak_status, pattern_mode,
    output ready
  );
endinterface

// ===== src/vmpt_front.sv =====
// ----------------------------------------------------------------------------
// vmpt_front
// Accepts command items and decodes them into operations for the queue.
// ----------------------------------------------------------------------------
module vmpt_front
  import vmpt_pkg::*;
(
  vmpt_in_if.sink in_ch,
  output logic    push_valid,
  input  logic    push_ready,
  output item_t   push_item
);

  op_t op;

  always_comb begin
    case (in_ch.cmd)
      CMD_TICK:  op = OP_TICK;
      CMD_START: op = OP_START;
      CMD_PROBE: op = OP_PROBE;
      default:   op = OP_NOP;
    endcase
  end

  assign push_valid           = in_ch.valid;
  assign in_ch.ready          = push_ready;
  assign push_item.op         = op;
  assign push_item.total_time = in_ch.total_time;
  assign push_item.on_time    = in_ch.on_time;
  assign push_item.off_time   = in_ch.off_time;
  assign push_item.bus_busy   = in_ch.bus_busy;
  assign push_item.pak_fault  = in_ch.pak_fault;

endmodule

// ===== src/vmpt_queue.sv =====
// ----------------------------------------------------------------------------
// vmpt_queue
// Short FIFO of decoded items between the front end and the execution side.
// ----------------------------------------------------------------------------
module vmpt_queue
  import vmpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/vmpt_back.sv =====
// ----------------------------------------------------------------------------
// vmpt_back
// Executes queued operations against the motor state and registers results.
// ----------------------------------------------------------------------------
module vmpt_back
  import vmpt_pkg::*;
#(
  parameter int TIME_WIDTH  = 16,
  parameter int RETRY_TICKS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  pop_valid,
  output logic  pop_ready,
  input  item_t pop_item,
  vmpt_out_if.source out_ch
);

  localparam int CNT_W = (RETRY_TICKS > 1) ? $clog2(RETRY_TICKS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RETRY_TICKS - 1);
  localparam logic [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1);

  pres_t                 pres_r, pres_nxt;
  logic                  probe_dis_r, probe_dis_nxt;
  logic [2:0]            mode_r, mode_nxt;
  logic [TIME_WIDTH-1:0] total_r, total_nxt;
  logic [TIME_WIDTH-1:0] on_len_r, on_len_nxt;
  logic [TIME_WIDTH-1:0] off_len_r, off_len_nxt;
  logic [TIME_WIDTH-1:0] phase_r, phase_nxt;
  logic                  off_ph_r, off_ph_nxt;
  logic                  issued_r, issued_nxt;
  logic [CNT_W-1:0]      refresh_r, refresh_nxt;
  logic [CNT_W-1:0]      retry_r, retry_nxt;

  logic                  out_valid_r;
  logic                  o_start_r, o_stop_r, o_init_r;
  pres_t                 o_pres_r;
  logic [2:0]            o_mode_r;

  logic take;
  logic probe_req, start_req, stop_req;
  logic o_start, o_stop, o_init;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    pres_nxt      = pres_r;
    probe_dis_nxt = probe_dis_r;
    mode_nxt      = mode_r;
    total_nxt     = total_r;
    on_len_nxt    = on_len_r;
    off_len_nxt   = off_len_r;
    phase_nxt     = phase_r;
    off_ph_nxt    = off_ph_r;
    issued_nxt    = issued_r;
    refresh_nxt   = refresh_r;
    retry_nxt     = retry_r;
    probe_req     = 1'b0;
    start_req     = 1'b0;
    stop_req      = 1'b0;
    o_start       = 1'b0;
    o_stop        = 1'b0;
    o_init        = 1'b0;

    case (pop_item.op)
      OP_TICK: begin
        if (pres_r != PRES_PRESENT) begin
          if (retry_r >= CNT_LAST) begin
            retry_nxt = '0;
            probe_req = 1'b1;
          end else begin
            retry_nxt = CNT_W'(retry_r + 1'b1);
          end
        end else if (mode_r == MODE_IDLE) begin
          if (refresh_r >= CNT_LAST) begin
            stop_req    = 1'b1;
            refresh_nxt = '0;
          end else begin
            refresh_nxt = CNT_W'(refresh_r + 1'b1);
          end
        end else if (mode_r < MODE_ACTIVE) begin
          stop_req = 1'b1;
          mode_nxt = 3'(mode_r - 3'd1);
        end else begin
          // first tick of a phase issues its access
          if (!issued_r) begin
            issued_nxt = 1'b1;
            start_req  = !off_ph_r;
            stop_req   = off_ph_r;
          end
          phase_nxt = TIME_WIDTH'(phase_r - TIME_ONE);
          if (phase_nxt == '0) begin
            phase_nxt  = off_ph_r ? on_len_r : off_len_r;
            off_ph_nxt = !off_ph_r;
            issued_nxt = 1'b0;
          end
          total_nxt = TIME_WIDTH'(total_r - TIME_ONE);
          if (total_nxt == '0) begin
            mode_nxt = MODE_STOPPING;
          end
        end
      end
      OP_START: begin
        if (pres_r == PRES_PRESENT) begin
          mode_nxt    = MODE_ACTIVE;
          total_nxt   = TIME_WIDTH'(pop_item.total_time);
          on_len_nxt  = TIME_WIDTH'(pop_item.on_time);
          phase_nxt   = TIME_WIDTH'(pop_item.on_time);
          off_len_nxt = TIME_WIDTH'(pop_item.off_time);
          off_ph_nxt  = 1'b0;
          issued_nxt  = 1'b0;
        end
      end
      OP_PROBE: begin
        probe_dis_nxt = 1'b0;
        probe_req     = 1'b1;
      end
      default: ;
    endcase

    if (probe_req && !probe_dis_nxt) begin
      if (pop_item.bus_busy) begin
        pres_nxt = PRES_ABSENT;
      end else begin
        o_init   = 1'b1;
        pres_nxt = pop_item.pak_fault ? PRES_ABSENT : PRES_PRESENT;
      end
      mode_nxt    = MODE_IDLE;
      total_nxt   = '0;
      off_ph_nxt  = 1'b0;
      on_len_nxt  = '0;
      off_len_nxt = '0;
      phase_nxt   = '0;
      issued_nxt  = 1'b0;
      refresh_nxt = '0;
      retry_nxt   = '0;
      stop_req    = (pres_nxt == PRES_PRESENT);
    end

    // motor access: only with the pak present and the bus free
    if ((start_req || stop_req) && pres_nxt == PRES_PRESENT && !pop_item.bus_busy) begin
      o_start = start_req;
      o_stop  = stop_req;
      if (pop_item.pak_fault) begin
        pres_nxt = PRES_ERROR;
        o_init   = 1'b1;
      end
    end

    if (pop_item.op == OP_PROBE && pres_nxt != PRES_PRESENT) begin
      probe_dis_nxt = 1'b1;
      pres_nxt      = PRES_ABSENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r      <= PRES_PRESENT;
      probe_dis_r <= 1'b0;
      mode_r      <= MODE_IDLE;
      total_r     <= '0;
      on_len_r    <= '0;
      off_len_r   <= '0;
      phase_r     <= '0;
      off_ph_r    <= 1'b0;
      issued_r    <= 1'b0;
      refresh_r   <= '0;
      retry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        pres_r      <= pres_nxt;
        probe_dis_r <= probe_dis_nxt;
        mode_r      <= mode_nxt;
        total_r     <= total_nxt;
        on_len_r    <= on_len_nxt;
        off_len_r   <= off_len_nxt;
        phase_r     <= phase_nxt;
        off_ph_r    <= off_ph_nxt;
        issued_r    <= issued_nxt;
        refresh_r   <= refresh_nxt;
        retry_r     <= retry_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_start_r <= o_start;
      o_stop_r  <= o_stop;
      o_init_r  <= o_init;
      o_pres_r  <= pres_nxt;
      o_mode_r  <= mode_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.start_sent   = o_start_r;
  assign out_ch.stop_sent    = o_stop_r;
  assign out_ch.init_sent    = o_init_r;
  assign out_ch.pak_status   = o_pres_r;
  assign out_ch.pattern_mode = o_mode_r;

endmodule

// ===== src/vibration_motor_pulse_timer.sv =====
// ----------------------------------------------------------------------------
// vibration_motor_pulse_timer
// Timed on/off vibration motor driver with pak presence tracking.
// ----------------------------------------------------------------------------
// Flow: an accepted item is written into the queue; the execute stage then pops
//   it from the queue and writes the result register.
// Throughput: one item per cycle while the receiver takes results; the execute
//   stage updates all counters together and the 2-entry queue absorbs output stalls.
// Reset: synchronous active-low rst_n; pak present, idle, all counters zero,
//   queue and result register empty.
module vibration_motor_pulse_timer
  import vmpt_pkg::*;
#(
  parameter int TIME_WIDTH  = 16,
  parameter int RETRY_TICKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  vmpt_in_if.sink     in_ch,
  vmpt_out_if.source  out_ch
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  vmpt_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  vmpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  vmpt_back #(
    .TIME_WIDTH  (TIME_WIDTH),
    .RETRY_TICKS (RETRY_TICKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

  // a single access per item: never both start and stop
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.start_sent && out_ch.stop_sent))
    else $error("start and stop issued for one item");

  // a start leaves the pak present or in error, never absent
  a_start_pres: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.start_sent) |-> (out_ch.pak_status != PRES_ABSENT))
    else $error("start issued with pak absent");

  // result mode stays within idle, stopping countdown or active
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pattern_mode <= MODE_ACTIVE))
    else $error("pattern mode out of range");

  // a popped item always lands in the result register next cycle
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> out_ch.valid)
    else $error("executed item produced no result");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for vibration_motor_pulse_timer. A queue of command items feeds a
// clocked driver. A monitor predicts each accepted item's result with a
// behavioral model of the pak presence, pattern and retry logic, and checks
// every result field. Both handshake sides idle in random bursts, and there
// is one long receiver hold-off to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import vmpt_pkg::*;

  localparam int          RETRY_TICKS = 16;
  localparam int          ITEM_TARGET = 1450;
  localparam int          TAIL_ITEMS  = 150;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] total_time;
    logic [15:0] on_time;
    logic [15:0] off_time;
    bit          bus_busy;
    bit          pak_fault;
  } motor_cmd_t;

  typedef struct {
    bit         start_sent;
    bit         stop_sent;
    bit         init_sent;
    pres_t      pak_status;
    logic [2:0] pattern_mode;
  } motor_result_t;

  logic clk;
  logic rst_n;

  vmpt_in_if  in_bus ();
  vmpt_out_if out_bus ();

  vibration_motor_pulse_timer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  motor_cmd_t    pending_q[$];
  motor_result_t expected_q[$];
  motor_cmd_t    drive_item;
  motor_result_t oldest_result;

  int  errors       = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;
  int  send_gap     = 0;
  int  stall_left   = 0;
  int  hold_left    = 0;
  bit  hold_done    = 0;
  bit  in_taken     = 0;

  // predicted block state
  pres_t       pak_presence;
  bit          probe_off;
  logic [2:0]  motor_mode;
  logic [15:0] total_left;
  logic [15:0] on_length;
  logic [15:0] off_length;
  logic [15:0] phase_left;
  bit          in_off_phase;
  bit          phase_issued;
  logic [3:0]  refresh_count;
  logic [3:0]  retry_count;

  // per-item access flags
  bit cur_busy;
  bit cur_fault;
  bit sent_start;
  bit sent_stop;
  bit sent_init;

  // --------------------------------------------------------------------------
  // motor behavior prediction
  // --------------------------------------------------------------------------
  function automatic void motor_clear();
    pak_presence  = PRES_PRESENT;
    probe_off     = 0;
    motor_mode    = MODE_IDLE;
    total_left    = '0;
    on_length     = '0;
    off_length    = '0;
    phase_left    = '0;
    in_off_phase  = 0;
    phase_issued  = 0;
    refresh_count = '0;
    retry_count   = '0;
  endfunction

  function automatic void motor_start_access();
    if (pak_presence != PRES_PRESENT || cur_busy) return;
    sent_start = 1;
    if (cur_fault) begin
      pak_presence = PRES_ERROR;
      sent_init    = 1;
    end
  endfunction

  // a faulting stop also sends an init and puts the pak in error
  function automatic void motor_stop_access();
    if (pak_presence != PRES_PRESENT || cur_busy) return;
    sent_stop = 1;
    if (cur_fault) begin
      pak_presence = PRES_ERROR;
      sent_init    = 1;
    end
  endfunction

  function automatic void pak_probe();
    if (probe_off) return;
    if (cur_busy) begin
      pak_presence = PRES_ABSENT;
    end else begin
      sent_init    = 1;
      pak_presence = cur_fault ? PRES_ABSENT : PRES_PRESENT;
    end
    motor_mode    = MODE_IDLE;
    total_left    = '0;
    in_off_phase  = 0;
    on_length     = '0;
    off_length    = '0;
    phase_left    = '0;
    phase_issued  = 0;
    refresh_count = '0;
    retry_count   = '0;
    if (pak_presence == PRES_PRESENT) motor_stop_access();
  endfunction

  function automatic void motor_tick();
    if (pak_presence != PRES_PRESENT) begin
      if (retry_count >= RETRY_TICKS - 1) begin
        retry_count = '0;
        pak_probe();
      end else begin
        retry_count++;
      end
      return;
    end
    if (motor_mode == MODE_IDLE) begin
      if (refresh_count >= RETRY_TICKS - 1) begin
        motor_stop_access();
        refresh_count = '0;
      end else begin
        refresh_count++;
      end
      return;
    end
    if (motor_mode < MODE_ACTIVE) begin
      motor_stop_access();
      motor_mode--;
      return;
    end
    if (!in_off_phase) begin
      if (!phase_issued) begin
        phase_issued = 1;
        motor_start_access();
      end
      phase_left--;
      if (phase_left == 0) begin
        phase_left   = off_length;
        in_off_phase = 1;
        phase_issued = 0;
      end
    end else begin
      if (!phase_issued) begin
        phase_issued = 1;
        motor_stop_access();
      end
      phase_left--;
      if (phase_left == 0) begin
        phase_left   = on_length;
        in_off_phase = 0;
        phase_issued = 0;
      end
    end
    total_left--;
    if (total_left == 0) motor_mode = MODE_STOPPING;
  endfunction

  function automatic motor_result_t motor_step(motor_cmd_t c);
    motor_result_t r;
    cur_busy   = c.bus_busy;
    cur_fault  = c.pak_fault;
    sent_start = 0;
    sent_stop  = 0;
    sent_init  = 0;
    case (c.cmd)
      CMD_TICK: motor_tick();
      CMD_START: begin
        if (pak_presence == PRES_PRESENT) begin
          motor_mode   = MODE_ACTIVE;
          total_left   = c.total_time;
          on_length    = c.on_time;
          phase_left   = c.on_time;
          off_length   = c.off_time;
          in_off_phase = 0;
          phase_issued = 0;
        end
      end
      CMD_PROBE: begin
        probe_off = 0;
        pak_probe();
        if (pak_presence != PRES_PRESENT) begin
          probe_off    = 1;
          pak_presence = PRES_ABSENT;
        end
      end
      default: ;
    endcase
    r.start_sent   = sent_start;
    r.stop_sent    = sent_stop;
    r.init_sent    = sent_init;
    r.pak_status   = pak_presence;
    r.pattern_mode = motor_mode;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_cmd(logic [1:0] cmd, logic [15:0] total, logic [15:0] on_t,
                                    logic [15:0] off_t, bit busy, bit fault);
    motor_cmd_t c;
    c.cmd        = cmd;
    c.total_time = total;
    c.on_time    = on_t;
    c.off_time   = off_t;
    c.bus_busy   = busy;
    c.pak_fault  = fault;
    pending_q.push_back(c);
  endfunction

  // ticks with random payload and occasional busy bus or pak fault
  function automatic void queue_ticks(int n);
    for (int i = 0; i < n; i++)
      queue_cmd(CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(0, 15) == 0, $urandom_range(0, 31) == 0);
  endfunction

  function automatic void queue_pattern();
    bit wide;
    int total;
    wide  = $urandom_range(0, 9) == 0;
    total = $urandom_range(1, 30);
    if (wide)
      queue_cmd(CMD_START, 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    else
      queue_cmd(CMD_START, 16'(total), 16'($urandom_range(0, 6)),
                16'($urandom_range(0, 6)),
                $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    queue_ticks(wide ? 40 : total + $urandom_range(0, 8));
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // input driver
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (send_gap == 0 && pending_q.size() > TAIL_ITEMS && $urandom_range(0, 11) == 0)
        send_gap = $urandom_range(1, 8);
      if (send_gap != 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        drive_item = pending_q.pop_front();
        in_bus.valid      <= 1'b1;
        in_bus.cmd        <= drive_item.cmd;
        in_bus.total_time <= drive_item.total_time;
        in_bus.on_time    <= drive_item.on_time;
        in_bus.off_time   <= drive_item.off_time;
        in_bus.bus_busy   <= drive_item.bus_busy;
        in_bus.pak_fault  <= drive_item.pak_fault;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: random stalls plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (!hold_done && results_seen >= 150) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left == 0 && stall_left == 0 && pending_q.size() > TAIL_ITEMS &&
          $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 8);
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on accept, check on result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      motor_clear();
      in_taken = 0;
    end else begin
      in_taken = in_bus.valid && in_bus.ready;
      if (in_taken) begin
        drive_item.cmd        = in_bus.cmd;
        drive_item.total_time = in_bus.total_time;
        drive_item.on_time    = in_bus.on_time;
        drive_item.off_time   = in_bus.off_time;
        drive_item.bus_busy   = in_bus.bus_busy;
        drive_item.pak_fault  = in_bus.pak_fault;
        expected_q.push_back(motor_step(drive_item));
      end
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result item with no expectation pending");
          errors++;
        end else begin
          oldest_result = expected_q.pop_front();
          check_field("start_sent", int'(oldest_result.start_sent),
                      int'(out_bus.start_sent));
          check_field("stop_sent", int'(oldest_result.stop_sent),
                      int'(out_bus.stop_sent));
          check_field("init_sent", int'(oldest_result.init_sent),
                      int'(out_bus.init_sent));
          check_field("pak_status", int'(oldest_result.pak_status),
                      int'(out_bus.pak_status));
          check_field("pattern_mode", int'(oldest_result.pattern_mode),
                      int'(out_bus.pattern_mode));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.cmd        = CMD_TICK;
    in_bus.total_time = '0;
    in_bus.on_time    = '0;
    in_bus.off_time   = '0;
    in_bus.bus_busy   = 1'b0;
    in_bus.pak_fault  = 1'b0;
    out_bus.ready     = 1'b0;

    // unused command with every payload bit set
    queue_cmd(CMD_UNUSED, '1, '1, '1, 1'b1, 1'b1);
    // short pattern: on, off, on, then three stopping ticks
    queue_cmd(CMD_START, 16'd3, 16'd1, 16'd1, 1'b0, 1'b0);
    repeat (6) queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    // largest lengths, then zero lengths that wrap
    queue_cmd(CMD_START, '1, '1, '1, 1'b0, 1'b0);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    queue_cmd(CMD_START, '0, '0, '0, 1'b0, 1'b0);
    repeat (2) queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    // busy bus skips the start; faulting stop puts the pak in error
    queue_cmd(CMD_START, 16'd4, 16'd2, 16'd1, 1'b0, 1'b0);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b1, 1'b0);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b1);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b1);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    // startup probe on busy bus, start while absent, faulting probe, clean probe
    queue_cmd(CMD_PROBE, '0, '0, '0, 1'b1, 1'b0);
    queue_cmd(CMD_START, 16'd5, 16'd1, 16'd1, 1'b0, 1'b0);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);
    queue_cmd(CMD_PROBE, '0, '0, '0, 1'b0, 1'b1);
    queue_cmd(CMD_PROBE, '0, '0, '0, 1'b0, 1'b0);
    // faulting start access
    queue_cmd(CMD_START, 16'd2, 16'd1, 16'd1, 1'b0, 1'b0);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b1);
    queue_cmd(CMD_TICK, '0, '0, '0, 1'b0, 1'b0);

    while (pending_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_pattern();
      end else if (pick < 75) begin
        queue_ticks($urandom_range(17, 40));
      end else if (pick < 85) begin
        queue_cmd(CMD_PROBE, 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        queue_ticks($urandom_range(5, 25));
      end else begin
        repeat ($urandom_range(1, 6))
          queue_cmd(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    16'($urandom),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_bus.valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
